// ===== hw/rtl/buddy_tree_bitmap_range_update_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef BUDDY_TREE_BITMAP_RANGE_UPDATE_ASSERT_SVH
`define BUDDY_TREE_BITMAP_RANGE_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTBRU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btbru assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTBRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btbru assertion failed");

`endif

// ===== hw/rtl/btbru_pkg.sv =====
package btbru_pkg;

  localparam int IDX_W          = 6;
  localparam int BITMAP_W       = 63;
  localparam int MAX_NODES_DEF  = 63;
  localparam int QUEUE_DEPTH    = 2;
  localparam logic [IDX_W-1:0] NODES_IN_USE_RST = 6'd63;

  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] start;
    logic [IDX_W-1:0] stop;
    logic [IDX_W-1:0] lim;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VISIT,
    ST_SPREAD,
    ST_CLIMB,
    ST_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/btbru_queue.sv =====
module btbru_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = btbru_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/btbru_front.sv =====
module btbru_front #(
  parameter int MAX_NODES = btbru_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [btbru_pkg::IDX_W-1:0] cfg_nodes_in_use,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_mode,
  input  logic [btbru_pkg::IDX_W-1:0] in_first_node,
  input  logic [btbru_pkg::IDX_W-1:0] in_range_length,
  input  logic                        cmd_full,
  output logic                        cmd_push,
  output btbru_pkg::cmd_t             cmd
);

  localparam int IDX_W = btbru_pkg::IDX_W;

  logic [IDX_W-1:0] nodes_in_use_r, nodes_in_use_nxt;
  logic [IDX_W-1:0] lim;
  logic [IDX_W:0]   range_end;
  logic [IDX_W-1:0] stop;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;
  assign cmd_push  = in_push && !cmd_full;

  always_comb begin
    nodes_in_use_nxt = nodes_in_use_r;
    if (cfg_valid && cfg_ready) begin
      nodes_in_use_nxt = cfg_nodes_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_in_use_r <= btbru_pkg::NODES_IN_USE_RST;
    end else begin
      nodes_in_use_r <= nodes_in_use_nxt;
    end
  end

  // The visited range is clipped to the limit; an empty range has start equal to stop.
  always_comb begin
    lim       = (nodes_in_use_r > IDX_W'(MAX_NODES)) ? IDX_W'(MAX_NODES) : nodes_in_use_r;
    range_end = (IDX_W + 1)'(in_first_node) + (IDX_W + 1)'(in_range_length);
    stop      = (range_end < (IDX_W + 1)'(lim)) ? range_end[IDX_W-1:0] : lim;
    cmd.mode  = in_mode;
    cmd.start = (in_first_node < stop) ? in_first_node : stop;
    cmd.stop  = stop;
    cmd.lim   = lim;
  end

endmodule

// ===== hw/rtl/btbru_back.sv =====
module btbru_back #(
  parameter int MAX_NODES = btbru_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_empty,
  input  btbru_pkg::cmd_t                cmd,
  output logic                           cmd_pop,
  input  logic                           res_full,
  output logic                           res_push,
  output logic [btbru_pkg::BITMAP_W-1:0] res_bitmap
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  btbru_pkg::back_state_t state_r, state_nxt;

  logic [MAX_NODES-1:0] marks_r, marks_nxt;
  logic [MAX_NODES-1:0] frontier_r, frontier_nxt;
  logic [MAX_NODES-1:0] spread_nf;
  logic [CNT_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     stop_r, stop_nxt;
  logic [CNT_W-1:0]     lim_r, lim_nxt;
  logic                 mode_r, mode_nxt;
  logic [IDX_W-1:0]     node_r, node_nxt;
  logic [IDX_W-1:0]     cur_idx;
  logic [IDX_W-1:0]     up_idx;
  logic                 at_end;
  logic                 cur_mark;
  logic                 up_mark;
  logic                 climb_stop;

  assign cur_idx    = cur_r[IDX_W-1:0];
  assign at_end     = (cur_r >= stop_r);
  assign cur_mark   = marks_r[cur_idx];
  assign up_idx     = (node_r - 1'b1) >> 1;
  assign up_mark    = marks_r[up_idx];
  assign climb_stop = (node_r == '0) || !up_mark;

  // One level of the downward spread: a zero child in use follows a parent just set.
  always_comb begin
    spread_nf = '0;
    for (int j = 1; j < MAX_NODES; j++) begin
      spread_nf[j] = frontier_r[(j - 1) >> 1] && !marks_r[j] && (CNT_W'(j) < lim_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btbru_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = btbru_pkg::ST_VISIT;
        end
      end
      btbru_pkg::ST_VISIT: begin
        if (at_end) begin
          state_nxt = btbru_pkg::ST_DONE;
        end else if (mode_r == btbru_pkg::MODE_SET && !cur_mark) begin
          state_nxt = btbru_pkg::ST_SPREAD;
        end else if (mode_r == btbru_pkg::MODE_CLEAR && cur_mark) begin
          state_nxt = btbru_pkg::ST_CLIMB;
        end
      end
      btbru_pkg::ST_SPREAD: begin
        if (spread_nf == '0) begin
          state_nxt = btbru_pkg::ST_VISIT;
        end
      end
      btbru_pkg::ST_CLIMB: begin
        if (climb_stop) begin
          state_nxt = btbru_pkg::ST_VISIT;
        end
      end
      btbru_pkg::ST_DONE: begin
        if (!res_full) begin
          state_nxt = btbru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btbru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = (state_r == btbru_pkg::ST_IDLE) && !cmd_empty;
    res_push   = (state_r == btbru_pkg::ST_DONE) && !res_full;
    res_bitmap = btbru_pkg::BITMAP_W'(marks_r);
  end

  always_comb begin
    marks_nxt    = marks_r;
    frontier_nxt = frontier_r;
    cur_nxt      = cur_r;
    stop_nxt     = stop_r;
    lim_nxt      = lim_r;
    mode_nxt     = mode_r;
    node_nxt     = node_r;
    unique case (state_r)
      btbru_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cur_nxt  = cmd.start[CNT_W-1:0];
          stop_nxt = cmd.stop[CNT_W-1:0];
          lim_nxt  = cmd.lim[CNT_W-1:0];
          mode_nxt = cmd.mode;
        end
      end
      btbru_pkg::ST_VISIT: begin
        if (!at_end) begin
          if (mode_r == btbru_pkg::MODE_SET && !cur_mark) begin
            marks_nxt[cur_idx]    = 1'b1;
            frontier_nxt          = '0;
            frontier_nxt[cur_idx] = 1'b1;
          end else if (mode_r == btbru_pkg::MODE_CLEAR && cur_mark) begin
            marks_nxt[cur_idx] = 1'b0;
            node_nxt           = cur_idx;
          end else begin
            cur_nxt = cur_r + 1'b1;
          end
        end
      end
      btbru_pkg::ST_SPREAD: begin
        marks_nxt    = marks_r | spread_nf;
        frontier_nxt = spread_nf;
        if (spread_nf == '0) begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      btbru_pkg::ST_CLIMB: begin
        if (climb_stop) begin
          cur_nxt = cur_r + 1'b1;
        end else begin
          marks_nxt[up_idx] = 1'b0;
          node_nxt          = up_idx;
        end
      end
      btbru_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= btbru_pkg::ST_IDLE;
      marks_r    <= '0;
      frontier_r <= '0;
    end else begin
      state_r    <= state_nxt;
      marks_r    <= marks_nxt;
      frontier_r <= frontier_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    stop_r <= stop_nxt;
    lim_r  <= lim_nxt;
    mode_r <= mode_nxt;
    node_r <= node_nxt;
  end

endmodule

// ===== hw/rtl/buddy_tree_bitmap_range_update.sv =====
// Keeps a heap-ordered tree of allocation marks (node i has children 2i+1 and 2i+2),
// cleared at reset, and applies one set-range or clear-range request per input
// transfer, returning the whole updated bitmap as one result transfer. Requests are
// classified on entry and queued (two deep); results wait in a two-deep queue, so
// the input side keeps taking requests while results are not yet popped, until the
// queues fill. A request is loaded from its queue and each index of its range is
// visited in turn; where that node changes, a set spreads down one tree level per
// step and a clear climbs one ancestor per step, and then the bitmap is pushed as
// the result. The single sequencer that walks the indices sets the rate; the request
// queue still takes a new request while the last one is being worked on.
// nodes_in_use may be written only while no request is in flight.
module buddy_tree_bitmap_range_update #(
  parameter int MAX_NODES = btbru_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [btbru_pkg::IDX_W-1:0]    cfg_nodes_in_use,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_mode,
  input  logic [btbru_pkg::IDX_W-1:0]    in_first_node,
  input  logic [btbru_pkg::IDX_W-1:0]    in_range_length,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [btbru_pkg::BITMAP_W-1:0] out_bitmap
);

  btbru_pkg::cmd_t                cmd_in;
  btbru_pkg::cmd_t                cmd_out;
  logic                           cmd_push;
  logic                           cmd_full;
  logic                           cmd_pop;
  logic                           cmd_empty;
  logic                           res_push;
  logic                           res_full;
  logic [btbru_pkg::BITMAP_W-1:0] res_bitmap;

  btbru_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_nodes_in_use(cfg_nodes_in_use),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_first_node   (in_first_node),
    .in_range_length (in_range_length),
    .cmd_full        (cmd_full),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  btbru_queue #(
    .WIDTH($bits(btbru_pkg::cmd_t)),
    .DEPTH(btbru_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_out),
    .empty(cmd_empty)
  );

  btbru_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_bitmap(res_bitmap)
  );

  btbru_queue #(
    .WIDTH(btbru_pkg::BITMAP_W),
    .DEPTH(btbru_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_bitmap),
    .full (res_full),
    .pop  (out_pop),
    .dout (out_bitmap),
    .empty(out_empty)
  );

endmodule

// ===== hw/rtl/btbru_checker.sv =====
`include "buddy_tree_bitmap_range_update_assert.svh"

module btbru_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_push,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic [btbru_pkg::BITMAP_W-1:0] out_bitmap
);

  // Both queues come out of reset empty.
  `BTBRU_ASSERT_IMPLY(a_empty_after_reset, clk, rst_n, $past(!rst_n), out_empty && !in_full)

  // The request queue can only fill up on an input transfer.
  `BTBRU_ASSERT_IMPLY(a_full_needs_push, clk, rst_n, $rose(in_full), $past(in_push))

  // A waiting result stays in place until it is popped.
  `BTBRU_ASSERT_NEXT(a_result_holds, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_bitmap))

endmodule

bind buddy_tree_bitmap_range_update btbru_checker u_btbru_checker (.*);

// ===== sim/buddy_tree_bitmap_range_update_checker.sv =====
`timescale 1ns / 100ps

module buddy_tree_bitmap_range_update_checker #(
  parameter int MAX_NODES = btbru_pkg::MAX_NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [btbru_pkg::IDX_W-1:0]    cfg_nodes_in_use,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic                           in_mode,
  input  logic [btbru_pkg::IDX_W-1:0]    in_first_node,
  input  logic [btbru_pkg::IDX_W-1:0]    in_range_length,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [btbru_pkg::BITMAP_W-1:0] out_bitmap,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  logic [btbru_pkg::BITMAP_W-1:0] tree_model;
  logic [btbru_pkg::IDX_W-1:0]    node_limit_q;
  logic [btbru_pkg::BITMAP_W-1:0] expected_bitmaps[$];
  int                             fails;
  int                             results_seen;

  function automatic logic [btbru_pkg::BITMAP_W-1:0] apply_range(
      input logic [btbru_pkg::BITMAP_W-1:0] marks,
      input logic [btbru_pkg::IDX_W-1:0] limit_reg,
      input logic mode,
      input logic [btbru_pkg::IDX_W-1:0] first,
      input logic [btbru_pkg::IDX_W-1:0] len);
    logic [btbru_pkg::BITMAP_W-1:0] m;
    logic [btbru_pkg::BITMAP_W-1:0] reach;
    int                             lim;
    int                             stop;
    int                             node;
    int                             up;
    m = marks;
    lim = int'(limit_reg);
    if (lim > MAX_NODES) begin
      lim = MAX_NODES;
    end
    stop = int'(first) + int'(len);
    for (int i = int'(first); i < lim && i < stop; i++) begin
      if (mode == btbru_pkg::MODE_SET) begin
        if (!m[i]) begin
          m[i] = 1'b1;
          // Descendants have higher indices, so one ascending pass follows the spread.
          reach = '0;
          reach[i] = 1'b1;
          for (int j = i + 1; j < lim; j++) begin
            if (reach[(j - 1) / 2] && !m[j]) begin
              m[j] = 1'b1;
              reach[j] = 1'b1;
            end
          end
        end
      end else begin
        if (m[i]) begin
          m[i] = 1'b0;
          node = i;
          while (node > 0) begin
            up = (node - 1) / 2;
            if (!m[up]) begin
              break;
            end
            m[up] = 1'b0;
            node = up;
          end
        end
      end
    end
    return m;
  endfunction

  always @(posedge clk) begin
    logic [btbru_pkg::BITMAP_W-1:0] want;
    if (!rst_n) begin
      tree_model = '0;
      node_limit_q = btbru_pkg::NODES_IN_USE_RST;
      expected_bitmaps.delete();
      fails = 0;
      results_seen = 0;
    end else begin
      if (!out_empty && out_pop) begin
        if (expected_bitmaps.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected result transfer: got %h", out_bitmap);
          end
          fails++;
        end else begin
          want = expected_bitmaps.pop_front();
          if (out_bitmap !== want) begin
            if (fails < 10) begin
              $display("bitmap mismatch on result %0d: expected %h, got %h",
                       results_seen, want, out_bitmap);
            end
            fails++;
          end
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        node_limit_q = cfg_nodes_in_use;
      end
      if (in_push && !in_full) begin
        tree_model = apply_range(tree_model, node_limit_q, in_mode, in_first_node,
                                 in_range_length);
        expected_bitmaps.push_back(tree_model);
      end
    end
    fail_count <= fails;
    pending <= expected_bitmaps.size();
    checked <= results_seen;
  end

endmodule

// ===== sim/tb_buddy_tree_bitmap_range_update.sv =====
`timescale 1ns / 100ps

module tb_buddy_tree_bitmap_range_update;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [btbru_pkg::IDX_W-1:0]    cfg_nodes_in_use;
  logic                           in_push;
  logic                           in_full;
  logic                           in_mode;
  logic [btbru_pkg::IDX_W-1:0]    in_first_node;
  logic [btbru_pkg::IDX_W-1:0]    in_range_length;
  logic                           out_empty;
  logic                           out_pop;
  logic [btbru_pkg::BITMAP_W-1:0] out_bitmap;

  int fail_count;
  int pending;
  int checked;
  int requests_sent;
  int limit_writes;
  int cur_limit;
  bit no_idle;

  buddy_tree_bitmap_range_update i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_nodes_in_use (cfg_nodes_in_use),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_first_node    (in_first_node),
    .in_range_length  (in_range_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_bitmap       (out_bitmap)
  );

  buddy_tree_bitmap_range_update_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_nodes_in_use (cfg_nodes_in_use),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_first_node    (in_first_node),
    .in_range_length  (in_range_length),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_bitmap       (out_bitmap),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_request(input logic mode, input int first, input int len);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_mode <= mode;
    in_first_node <= first[btbru_pkg::IDX_W-1:0];
    in_range_length <= len[btbru_pkg::IDX_W-1:0];
    @(posedge clk);
    while (in_full) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_node_limit(input int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_nodes_in_use <= value[btbru_pkg::IDX_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = value;
    limit_writes++;
  endtask

  task automatic random_request();
    int sel;
    int lim_hi;
    int first;
    int len;
    logic mode;
    sel = $urandom_range(0, 99);
    mode = 1'($urandom_range(0, 1));
    lim_hi = (cur_limit == 0) ? 0 : cur_limit - 1;
    if (sel < 40) begin
      first = $urandom_range(0, lim_hi);
      len = $urandom_range(1, 4);
    end else if (sel < 65) begin
      first = $urandom_range(0, lim_hi);
      len = 1;
    end else if (sel < 80) begin
      first = $urandom_range(0, lim_hi);
      len = $urandom_range(0, 63);
    end else if (sel < 92) begin
      first = $urandom_range(0, 63);
      len = $urandom_range(0, 63);
    end else if (sel < 96) begin
      first = $urandom_range(0, 63);
      len = 0;
    end else begin
      first = 63;
      len = $urandom_range(0, 63);
    end
    send_request(mode, first, len);
  endtask

  initial begin
    int phase_limits[13];
    rst_n = 1'b0;
    cfg_valid <= 1'b0;
    cfg_nodes_in_use <= '0;
    in_push <= 1'b0;
    in_mode <= btbru_pkg::MODE_SET;
    in_first_node <= '0;
    in_range_length <= '0;
    no_idle <= 1'b0;
    requests_sent = 0;
    limit_writes = 0;
    cur_limit = int'(btbru_pkg::NODES_IN_USE_RST);
    phase_limits = '{63, 1, 0, 2, 3, 62, 7, 15, 31, 32, 48, 0, 0};
    phase_limits[11] = $urandom_range(1, 63);
    phase_limits[12] = $urandom_range(1, 63);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first under the reset limit, then under limits of 0, 1 and 63.
    send_request(btbru_pkg::MODE_SET, 0, 1);
    send_request(btbru_pkg::MODE_CLEAR, 62, 1);
    send_request(btbru_pkg::MODE_CLEAR, 0, 0);
    send_request(btbru_pkg::MODE_SET, 63, 63);
    send_request(btbru_pkg::MODE_SET, 5, 63);
    send_request(btbru_pkg::MODE_CLEAR, 0, 63);
    send_request(btbru_pkg::MODE_SET, 62, 63);
    send_request(btbru_pkg::MODE_SET, 31, 32);
    send_request(btbru_pkg::MODE_CLEAR, 20, 10);
    send_request(btbru_pkg::MODE_SET, 0, 63);
    send_request(btbru_pkg::MODE_CLEAR, 0, 1);
    send_request(btbru_pkg::MODE_CLEAR, 1, 62);
    send_request(btbru_pkg::MODE_SET, 0, 0);
    send_request(btbru_pkg::MODE_SET, 0, 63);
    write_node_limit(0);
    send_request(btbru_pkg::MODE_CLEAR, 0, 63);
    send_request(btbru_pkg::MODE_SET, 0, 63);
    write_node_limit(1);
    send_request(btbru_pkg::MODE_CLEAR, 0, 63);
    send_request(btbru_pkg::MODE_SET, 0, 5);
    write_node_limit(63);
    send_request(btbru_pkg::MODE_CLEAR, 32, 31);
    send_request(btbru_pkg::MODE_SET, 40, 63);
    send_request(btbru_pkg::MODE_CLEAR, 63, 1);

    for (int p = 0; p < 13; p++) begin
      write_node_limit(phase_limits[p]);
      no_idle <= (p % 4 == 3);
      for (int n = 0; n < 150; n++) begin
        if (n == 75) begin
          drain_results();
        end
        random_request();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("Ran %0d set/clear range requests across %0d node-limit writes,", requests_sent,
             limit_writes);
    $display("including zero and full limits; %0d bitmap results compared.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  initial begin
    #60000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/btbru_pkg.sv
hw/rtl/btbru_queue.sv
hw/rtl/btbru_front.sv
hw/rtl/btbru_back.sv
hw/rtl/buddy_tree_bitmap_range_update.sv
hw/rtl/btbru_checker.sv
sim/buddy_tree_bitmap_range_update_checker.sv
sim/tb_buddy_tree_bitmap_range_update.sv
